[rtl/atsc_pkg.sv]
package atsc_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_DRIVE_GAIN = 2'd0;
    localparam logic [1:0] REG_NORM_RECIP = 2'd1;
    localparam logic [1:0] REG_PASS_COUNT = 2'd2;

    localparam int unsigned GAIN_BITS  = 16;
    localparam int unsigned RECIP_BITS = 24;
    localparam int unsigned COUNT_BITS = 8;
    localparam int unsigned CFG_BITS   = 24;

    // angle accumulator: Q2.30 plus sign
    localparam int unsigned ANGLE_BITS = 33;

    localparam logic [GAIN_BITS-1:0]  DRIVE_RESET = 16'd4096;
    localparam logic [RECIP_BITS-1:0] RECIP_RESET = 24'd83460;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 8'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_WALK,
        ST_RND,
        ST_FIN
    } state_t;

    // atan(2^-i) in Q2.30, truncated
    function automatic logic [31:0] atan_q30(input int unsigned idx);
        logic [31:0] a;
        begin
            case (idx)
                0:  a = 32'h3243F6A8;
                1:  a = 32'h1DAC6705;
                2:  a = 32'h0FADBAFC;
                3:  a = 32'h07F56EA6;
                4:  a = 32'h03FEAB76;
                5:  a = 32'h01FFD55B;
                6:  a = 32'h00FFFAAA;
                7:  a = 32'h007FFF55;
                8:  a = 32'h003FFFEA;
                9:  a = 32'h001FFFFD;
                10: a = 32'h000FFFFF;
                11: a = 32'h0007FFFF;
                12: a = 32'h0003FFFF;
                13: a = 32'h0001FFFF;
                14: a = 32'h0000FFFF;
                15: a = 32'h00007FFF;
                16: a = 32'h00003FFF;
                17: a = 32'h00001FFF;
                18: a = 32'h00000FFF;
                19: a = 32'h000007FF;
                20: a = 32'h000003FF;
                21: a = 32'h000001FF;
                22: a = 32'h000000FF;
                23: a = 32'h0000007F;
                24: a = 32'h0000003F;
                25: a = 32'h0000001F;
                26: a = 32'h0000000F;
                27: a = 32'h00000007;
                28: a = 32'h00000003;
                29: a = 32'h00000001;
                default: a = 32'h00000000;
            endcase
            return a;
        end
    endfunction

endpackage

[rtl/atsc_cell.sv]
// one vectoring CORDIC step
module atsc_cell #(
    parameter int unsigned W    = 34,
    parameter int unsigned STEP = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   valid_in,
    input  logic signed [W-1:0]                    x_in,
    input  logic signed [W-1:0]                    y_in,
    input  logic signed [atsc_pkg::ANGLE_BITS-1:0] z_in,
    output logic                                   valid_out,
    output logic signed [W-1:0]                    x_out,
    output logic signed [W-1:0]                    y_out,
    output logic signed [atsc_pkg::ANGLE_BITS-1:0] z_out
);

    localparam logic signed [atsc_pkg::ANGLE_BITS-1:0] ANG =
        $signed({1'b0, atsc_pkg::atan_q30(STEP)});

    logic                                   valid_reg;
    logic signed [W-1:0]                    x_reg, x_next;
    logic signed [W-1:0]                    y_reg, y_next;
    logic signed [atsc_pkg::ANGLE_BITS-1:0] z_reg, z_next;
    logic signed [W-1:0]                    dx, dy;

    // >>> floors, as required
    assign dx = y_in >>> STEP;
    assign dy = x_in >>> STEP;

    always_comb
    begin
        if (!y_in[W-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANG;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;

endmodule

[rtl/atsc_norm.sv]
// angle times 1/atan(k), rounded and clamped to a sample magnitude
module atsc_norm #(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   load,
    input  logic signed [atsc_pkg::ANGLE_BITS-1:0] angle,
    input  logic [atsc_pkg::RECIP_BITS-1:0]        recip,
    input  logic                                   neg,
    output logic [SAMPLE_BITS-1:0]                 mag
);

    localparam int unsigned F  = SAMPLE_BITS - 1;
    localparam int unsigned ZB = atsc_pkg::ANGLE_BITS - 2;
    localparam int unsigned PB = ZB + atsc_pkg::RECIP_BITS;
    localparam int unsigned SH = 46 - F;
    localparam int unsigned RB = PB + 1 - SH;

    logic [ZB-1:0]          zc;
    logic [PB-1:0]          prod_reg;
    logic [PB:0]            rsum;
    logic [RB-1:0]          r;
    logic [RB-1:0]          lim;

    assign zc = angle[atsc_pkg::ANGLE_BITS-1] ? '0 : angle[ZB-1:0];

    always_ff @(posedge clk)
    begin
        if (load)
            prod_reg <= zc * recip;
    end

    assign rsum = {1'b0, prod_reg} + ((PB+1)'(1) << (SH - 1));
    assign r    = rsum[PB:SH];
    assign lim  = neg ? (RB'(1) << F) : ((RB'(1) << F) - RB'(1));
    assign mag  = (r > lim) ? lim[SAMPLE_BITS-1:0] : r[SAMPLE_BITS-1:0];

endmodule

[rtl/arctan_soft_clip_distortion.sv]
// Each accepted word makes P passes along the CORDIC cell row,
// P = min(pass_count, MAX_PASSES); with P zero it makes none.
// Throughput: one word at a time; the next word is taken as soon as the
// previous result sits in the output register. Each pass walks the cell
// row once, then registers one multiply and rounds in ST_RND.
// Reset (rst_n, async, low): control cleared, registers back to defaults.
module arctan_soft_clip_distortion #(
    parameter int unsigned SAMPLE_BITS  = 16,
    parameter int unsigned MAX_PASSES   = 255,
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [atsc_pkg::CFG_BITS-1:0]       cfg_data,
    // input word
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    // output word
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_BITS-1:0]       sample_out
);

    localparam int unsigned F  = SAMPLE_BITS - 1;
    // datapath width: k*|x| reaches 2^(16+F), CORDIC gain adds under a bit
    localparam int unsigned W  = SAMPLE_BITS + 18;
    localparam int unsigned PW = $clog2(MAX_PASSES + 1);
    localparam int unsigned CW = (PW > atsc_pkg::COUNT_BITS) ? PW : atsc_pkg::COUNT_BITS;
    localparam int unsigned AB = atsc_pkg::ANGLE_BITS;
    localparam logic signed [W-1:0] X0 = W'(1) << (12 + F);
    localparam logic [CW-1:0] MAXP = CW'(MAX_PASSES);

    // configuration registers
    logic [atsc_pkg::GAIN_BITS-1:0]  drive_reg;
    logic [atsc_pkg::RECIP_BITS-1:0] recip_reg;
    logic [atsc_pkg::COUNT_BITS-1:0] count_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg     <= atsc_pkg::DRIVE_RESET;
            recip_reg     <= atsc_pkg::RECIP_RESET;
            count_cfg_reg <= atsc_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                atsc_pkg::REG_DRIVE_GAIN: drive_reg <= cfg_data[atsc_pkg::GAIN_BITS-1:0];
                atsc_pkg::REG_NORM_RECIP: recip_reg <= cfg_data[atsc_pkg::RECIP_BITS-1:0];
                atsc_pkg::REG_PASS_COUNT: count_cfg_reg <= cfg_data[atsc_pkg::COUNT_BITS-1:0];
                default: ; // unknown index: write dropped
            endcase
        end
    end

    // sequencer
    atsc_pkg::state_t state_reg, state_next;
    logic [PW-1:0]          cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0] m_reg, m_next;
    logic                   neg_reg, neg_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_reg, out_next;

    logic                   accept;
    logic                   out_free;
    logic                   inject;
    logic [CW-1:0]          passes;
    logic [SAMPLE_BITS-1:0] m_in;
    logic [SAMPLE_BITS-1:0] norm_mag;

    // cell row
    logic                 valid_c [0:CORDIC_STEPS];
    logic signed [W-1:0]  x_c     [0:CORDIC_STEPS];
    logic signed [W-1:0]  y_c     [0:CORDIC_STEPS];
    logic signed [AB-1:0] z_c     [0:CORDIC_STEPS];
    logic [CORDIC_STEPS:0] valid_vec;
    logic [SAMPLE_BITS+atsc_pkg::GAIN_BITS-1:0] y_start;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != atsc_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign inject   = (state_reg == atsc_pkg::ST_PASS);

    always_comb
    begin
        if (CW'(count_cfg_reg) > MAXP)
            passes = MAXP;
        else
            passes = CW'(count_cfg_reg);
    end

    // magnitude; the most negative sample wraps to 2^F by itself
    assign m_in = sample_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_in)
                                           : SAMPLE_BITS'(sample_in);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        m_next         = m_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        case (state_reg)
            atsc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    m_next   = m_in;
                    neg_next = sample_in[SAMPLE_BITS-1];
                    cnt_next = passes[PW-1:0];
                    if (passes == '0)
                        state_next = atsc_pkg::ST_FIN;
                    else
                        state_next = atsc_pkg::ST_PASS;
                end
            end
            atsc_pkg::ST_PASS:
                state_next = atsc_pkg::ST_WALK;
            atsc_pkg::ST_WALK:
            begin
                if (valid_c[CORDIC_STEPS])
                    state_next = atsc_pkg::ST_RND;
            end
            atsc_pkg::ST_RND:
            begin
                m_next   = norm_mag;
                cnt_next = cnt_reg - PW'(1);
                if (cnt_reg == PW'(1))
                    state_next = atsc_pkg::ST_FIN;
                else
                    state_next = atsc_pkg::ST_PASS;
            end
            atsc_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = neg_reg ? SAMPLE_BITS'(-m_reg) : m_reg;
                    state_next     = atsc_pkg::ST_IDLE;
                end
            end
            default:
                state_next = atsc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= atsc_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        neg_reg <= neg_next;
        out_reg <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = $signed(out_reg);

    // row head: X = 1.0, Y = k*|x|, Z = 0
    assign y_start    = drive_reg * m_reg;
    assign valid_c[0] = inject;
    assign x_c[0]     = X0;
    assign y_c[0]     = $signed(W'(y_start));
    assign z_c[0]     = '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        atsc_cell #(
            .W    (W),
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_c[i]),
            .x_in      (x_c[i]),
            .y_in      (y_c[i]),
            .z_in      (z_c[i]),
            .valid_out (valid_c[i+1]),
            .x_out     (x_c[i+1]),
            .y_out     (y_c[i+1]),
            .z_out     (z_c[i+1])
        );
    end

    for (genvar j = 0; j <= CORDIC_STEPS; j++)
    begin : g_vvec
        assign valid_vec[j] = valid_c[j];
    end

    // product registered as the angle leaves the row; rounded in ST_RND
    atsc_norm #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_norm (
        .clk   (clk),
        .load  (valid_c[CORDIC_STEPS]),
        .angle (z_c[CORDIC_STEPS]),
        .recip (recip_reg),
        .neg   (neg_reg),
        .mag   (norm_mag)
    );

    // at most one pass in flight along the row
    a_one_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) <= 1)
        else $error("more than one pass in the cell row");

    a_tail_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        valid_c[CORDIC_STEPS] |-> state_reg == atsc_pkg::ST_WALK)
        else $error("row tail valid outside walk");

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == atsc_pkg::ST_WALK || state_reg == atsc_pkg::ST_RND)
        |-> cnt_reg != '0)
        else $error("pass running with zero count");

    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == atsc_pkg::ST_FIN && out_free |=> out_valid_reg)
        else $error("finished word not registered");

endmodule

[tb/tb_arctan_soft_clip_distortion.sv]
`timescale 1ns / 100ps

module tb_arctan_soft_clip_distortion;

    // index outside the register map; writes to it must have no effect
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         RANDOM_WORDS = 560;

    // atan(2^-i) in Q2.30, truncated, first sixteen CORDIC steps
    localparam logic [31:0] ANGLE_STEP_Q30 [0:15] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF
    };

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [1:0]                        cfg_index;
    logic [atsc_pkg::CFG_BITS-1:0]     cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic signed [15:0]                sample_in;
    logic                              out_valid;
    logic                              out_stall;
    logic signed [15:0]                sample_out;

    // shadow copy of the register file, mirrors every write we issue
    logic [atsc_pkg::GAIN_BITS-1:0]    drive_k;
    logic [atsc_pkg::RECIP_BITS-1:0]   inv_angle_k;
    logic [atsc_pkg::COUNT_BITS-1:0]   num_passes;

    logic signed [15:0]                shaped_queue[$];
    int                                err_count;
    int                                words_in;
    int                                words_out;
    int                                send_idle_pct;
    int                                recv_idle_pct;
    bit                                hold_req;

    // one directed row: register setting, sample and, where obvious, the answer
    typedef struct {
        logic [atsc_pkg::GAIN_BITS-1:0]  gain;
        logic [atsc_pkg::RECIP_BITS-1:0] recip;
        logic [atsc_pkg::COUNT_BITS-1:0] passes;
        logic signed [15:0]              smp;
        bit                              known;
        logic signed [15:0]              answer;
    } shaper_row_t;

    localparam int N_ROWS = 20;
    shaper_row_t rows [0:N_ROWS-1];

    arctan_soft_clip_distortion u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // --------------------------------------------------------------------
    // Predictor: one arctangent pass on a magnitude in Q1.15
    // --------------------------------------------------------------------
    function automatic longint unsigned atan_pass(input longint unsigned mag,
                                                  input bit neg);
        longint          vx;
        longint          vy;
        longint          ang;
        longint          sx;
        longint          sy;
        logic [63:0]     prod;
        longint unsigned rnd;
        longint unsigned lim;
        vx  = longint'(1) << 27;
        vy  = longint'(drive_k) * longint'(mag);
        ang = 0;
        for (int i = 0; i < 16; i++)
        begin
            sx = vy >>> i;     // floors, as the hardware shifter does
            sy = vx >>> i;
            if (vy >= 0)
            begin
                vx  = vx + sx;
                vy  = vy - sy;
                ang = ang + longint'(ANGLE_STEP_Q30[i]);
            end
            else
            begin
                vx  = vx - sx;
                vy  = vy + sy;
                ang = ang - longint'(ANGLE_STEP_Q30[i]);
            end
        end
        if (ang < 0)
            ang = 0;
        prod = 64'(ang) * 64'(inv_angle_k);
        rnd  = (prod + (64'd1 << 30)) >> 31;
        lim  = neg ? 64'd32768 : 64'd32767;
        return (rnd > lim) ? lim : rnd;
    endfunction

    function automatic logic signed [15:0] shaped_sample(input logic signed [15:0] s);
        bit              neg;
        longint unsigned mag;
        neg = s[15];
        mag = neg ? longint'(-longint'(s)) : longint'(s);
        if (num_passes == 0)
            return s;
        for (int p = 0; p < num_passes; p++)
            mag = atan_pass(mag, neg);
        return neg ? 16'(-longint'(mag)) : 16'(mag);
    endfunction

    // --------------------------------------------------------------------
    // Register writes, only ever issued while the block is empty
    // --------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx,
                             input logic [atsc_pkg::CFG_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            atsc_pkg::REG_DRIVE_GAIN: drive_k     = val[atsc_pkg::GAIN_BITS-1:0];
            atsc_pkg::REG_NORM_RECIP: inv_angle_k = val[atsc_pkg::RECIP_BITS-1:0];
            atsc_pkg::REG_PASS_COUNT: num_passes  = val[atsc_pkg::COUNT_BITS-1:0];
            default: ;
        endcase
    endtask

    // stop offering words and wait until every shaped word is back
    task automatic drain;
        in_valid <= 1'b0;
        while (shaped_queue.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_shaper(input logic [atsc_pkg::GAIN_BITS-1:0] g,
                              input logic [atsc_pkg::RECIP_BITS-1:0] r,
                              input logic [atsc_pkg::COUNT_BITS-1:0] c,
                              input bit all);
        drain();
        if (all || g != drive_k)
            write_reg(atsc_pkg::REG_DRIVE_GAIN, atsc_pkg::CFG_BITS'(g));
        if (all || r != inv_angle_k)
            write_reg(atsc_pkg::REG_NORM_RECIP, atsc_pkg::CFG_BITS'(r));
        if (all || c != num_passes)
            write_reg(atsc_pkg::REG_PASS_COUNT, atsc_pkg::CFG_BITS'(c));
    endtask

    // offer one word; the expectation is queued on the accepting edge
    task automatic send_word(input logic signed [15:0] s, input bit known,
                             input logic signed [15:0] answer);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= s;
        do
            @(posedge clk);
        while (in_stall);
        shaped_queue.push_back(known ? answer : shaped_sample(s));
        words_in++;
    endtask

    // --------------------------------------------------------------------
    // Receiver: random stall, plus one long hold-off on request
    // --------------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    // output checker: oldest expectation against each accepted word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (shaped_queue.size() == 0)
            begin
                $error("sample_out: unexpected word, actual %0d", sample_out);
                err_count++;
            end
            else
            begin
                if (sample_out !== shaped_queue[0])
                begin
                    $error("sample_out: expected %0d, actual %0d",
                           shaped_queue[0], sample_out);
                    err_count++;
                end
                void'(shaped_queue.pop_front());
            end
            words_out++;
        end
    end

    // --------------------------------------------------------------------
    // Stimulus
    // --------------------------------------------------------------------
    initial
    begin
        int          burst;
        int          sent;
        int          phase;
        logic [15:0] g;
        logic [23:0] r;
        logic [7:0]  c;

        // directed rows: defaults, bypass, zero drive/reciprocal, saturation, multi-pass
        rows[0]  = '{16'd4096, 24'd83460, 8'd1, 16'sd0, 1'b1, 16'sd0};
        rows[1]  = '{16'd4096, 24'd83460, 8'd1, 16'sd32767, 1'b0, 16'sd0};
        rows[2]  = '{16'd4096, 24'd83460, 8'd1, -16'sd32768, 1'b0, 16'sd0};
        rows[3]  = '{16'd4096, 24'd83460, 8'd1, 16'sd1, 1'b0, 16'sd0};
        rows[4]  = '{16'd4096, 24'd83460, 8'd1, -16'sd1, 1'b0, 16'sd0};
        rows[5]  = '{16'd4096, 24'd83460, 8'd0, 16'sd32767, 1'b1, 16'sd32767};
        rows[6]  = '{16'd4096, 24'd83460, 8'd0, -16'sd32768, 1'b1, -16'sd32768};
        rows[7]  = '{16'd4096, 24'd83460, 8'd0, 16'sh1234, 1'b1, 16'sh1234};
        rows[8]  = '{16'd0, 24'd83460, 8'd1, 16'sd20000, 1'b1, 16'sd0};
        rows[9]  = '{16'd0, 24'd83460, 8'd1, -16'sd20000, 1'b1, 16'sd0};
        rows[10] = '{16'd4096, 24'd0, 8'd1, 16'sd12345, 1'b1, 16'sd0};
        rows[11] = '{16'd4096, 24'd0, 8'd1, -16'sd32768, 1'b1, 16'sd0};
        rows[12] = '{16'hFFFF, 24'hFFFFFF, 8'd1, 16'sd16384, 1'b1, 16'sd32767};
        rows[13] = '{16'hFFFF, 24'hFFFFFF, 8'd1, -16'sd16384, 1'b1, -16'sd32768};
        rows[14] = '{16'hFFFF, 24'hFFFFFF, 8'd1, -16'sd32768, 1'b1, -16'sd32768};
        rows[15] = '{16'hFFFF, 24'hFFFFFF, 8'd1, 16'sd1, 1'b0, 16'sd0};
        rows[16] = '{16'hFFFF, 24'd83460, 8'd3, 16'sd9000, 1'b0, 16'sd0};
        rows[17] = '{16'd1, 24'd1, 8'd2, 16'sd32767, 1'b0, 16'sd0};
        rows[18] = '{16'd4096, 24'd83460, 8'd255, 16'sd12345, 1'b0, 16'sd0};
        rows[19] = '{16'd4096, 24'd83460, 8'd255, -16'sd777, 1'b0, 16'sd0};

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = atsc_pkg::REG_DRIVE_GAIN;
        cfg_data      = '0;
        in_valid      = 1'b0;
        sample_in     = '0;
        hold_req      = 1'b0;
        err_count     = 0;
        words_in      = 0;
        words_out     = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        drive_k       = atsc_pkg::DRIVE_RESET;
        inv_angle_k   = atsc_pkg::RECIP_RESET;
        num_passes    = atsc_pkg::COUNT_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a write to the spare index must leave the defaults in place
        write_reg(REG_UNUSED, 24'hFFFFFF);

        for (int i = 0; i < N_ROWS; i++)
        begin
            set_shaper(rows[i].gain, rows[i].recip, rows[i].passes, 1'b0);
            send_word(rows[i].smp, rows[i].known, rows[i].answer);
        end

        // random phases: each one a fresh register setting
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS)
        begin
            case (phase % 5)
                0: begin g = 16'hFFFF; r = 24'($urandom_range(1, 24'hFFFFFF)); end
                1: begin g = 16'd1;    r = 24'hFFFFFF; end
                2: begin g = 16'($urandom_range(1, 65535)); r = 24'd1; end
                default: begin
                    g = 16'($urandom_range(1, 65535));
                    r = 24'($urandom_range(20000, 200000));
                end
            endcase
            c = (phase == 6) ? 8'd255 : 8'($urandom_range(0, 4));
            burst = (c == 8'd255) ? 6 : 40;
            set_shaper(g, r, c, 1'b1);

            // idling pattern moves through three regimes over the run
            if (sent < RANDOM_WORDS / 3)
            begin
                send_idle_pct = 12;
                recv_idle_pct = 63;
            end
            else if (sent < 2 * RANDOM_WORDS / 3)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 12;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // one phase with the receiver holding off while words keep coming
            if (phase == 9)
            begin
                send_idle_pct = 0;
                hold_req = 1'b1;
            end

            for (int k = 0; k < burst; k++)
                send_word(16'($urandom()), 1'b0, 16'sd0);
            sent += burst;
            phase++;

            // sender pauses here until the block has handed back everything
            if (phase == 4)
                drain();
        end

        drain();
        repeat (20) @(posedge clk);

        $display("%0d words shaped over %0d register settings, all fields and stall regimes",
                 words_in, phase + N_ROWS);
        $display("%0d result words checked, %0d mismatches", words_out, err_count);
        if (err_count == 0 && shaped_queue.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
